/* rtl/core/sslseq_pkg.sv */
// shared types, constants and the character decoder of the seven-segment link sequencer
package sslseq_pkg;

    // transaction opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // frame phase codes
    localparam logic [3:0] PH_START_CMD = 4'd0;
    localparam logic [3:0] PH_BYTE_CMD  = 4'd1;
    localparam logic [3:0] PH_STOP_CMD  = 4'd2;
    localparam logic [3:0] PH_START_ADR = 4'd3;
    localparam logic [3:0] PH_BYTE_ADR  = 4'd4;
    localparam logic [3:0] PH_DIGIT_0   = 4'd5;
    localparam logic [3:0] PH_DIGIT_1   = 4'd6;
    localparam logic [3:0] PH_DIGIT_2   = 4'd7;
    localparam logic [3:0] PH_DIGIT_3   = 4'd8;
    localparam logic [3:0] PH_STOP_END  = 4'd9;

    // sub step codes (start/stop edges and ack clock)
    localparam logic [1:0] SUB_FIRST  = 2'd0;
    localparam logic [1:0] SUB_SECOND = 2'd1;
    localparam logic [1:0] SUB_THIRD  = 2'd2;

    // bit step codes
    localparam logic [1:0] BIT_CLK_LOW  = 2'd0;
    localparam logic [1:0] BIT_DATA_SET = 2'd1;
    localparam logic [1:0] BIT_CLK_HIGH = 2'd2;

    localparam logic [3:0] LAST_BIT_IDX = 4'd7;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // command bytes
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;

    // segment patterns
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DIGITS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_DASH = 8'h2D;

    // line and frame control state
    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] sub_step;
        logic [3:0] bit_index;
        logic [1:0] bit_step;
        logic       active;
        logic       clk_line;
        logic       dio_line;
    } t_frame_state;

    typedef logic [7:0] t_digit_bytes [4];

    // ascii code to segment byte
    function automatic logic [7:0] decode_char(input logic [7:0] c);
        logic [7:0] offs;
        offs = c - ASCII_ZERO;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            return SEG_DIGITS[offs[3:0]];
        end else if (c == ASCII_DASH) begin
            return SEG_DASH;
        end
        return SEG_BLANK;
    endfunction

endpackage

/* rtl/core/sslseq_in_if.sv */
// input channel: opcode and four characters with valid/ready
interface sslseq_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic [7:0] char_third;
    logic [7:0] char_fourth;

    modport source (
        output valid, opcode, char_first, char_second, char_third, char_fourth,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_first, char_second, char_third, char_fourth,
        output ready
    );
endinterface

/* rtl/core/sslseq_out_if.sv */
// output channel: line levels and busy flag with valid/ready
interface sslseq_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic busy_res;

    modport source (
        output valid, clk_level, dio_level, busy_res,
        input  ready
    );
    modport sink (
        input  valid, clk_level, dio_level, busy_res,
        output ready
    );
endinterface

/* rtl/core/sslseq_frame_step.sv */
// next-state logic of the two-wire frame for one tick
module sslseq_frame_step (
    input  sslseq_pkg::t_frame_state i_cur,
    input  sslseq_pkg::t_digit_bytes i_digits,
    output sslseq_pkg::t_frame_state o_nxt
);

    logic [7:0] byte_sel;
    logic [3:0] digit_offs;

    // byte sent in the current phase
    always_comb begin
        digit_offs = i_cur.phase - sslseq_pkg::PH_DIGIT_0;
        if (i_cur.phase == sslseq_pkg::PH_BYTE_CMD) begin
            byte_sel = sslseq_pkg::CMD_DATA;
        end else if (i_cur.phase == sslseq_pkg::PH_BYTE_ADR) begin
            byte_sel = sslseq_pkg::CMD_ADDR;
        end else if (i_cur.phase >= sslseq_pkg::PH_DIGIT_0
                     && i_cur.phase <= sslseq_pkg::PH_DIGIT_3) begin
            byte_sel = i_digits[digit_offs[1:0]];
        end else begin
            byte_sel = 8'h00;
        end
    end

    // one step of the frame
    always_comb begin
        o_nxt = i_cur;
        if (i_cur.phase == sslseq_pkg::PH_START_CMD
            || i_cur.phase == sslseq_pkg::PH_START_ADR) begin
            // start condition: both high, then data and clock low
            if (i_cur.sub_step == sslseq_pkg::SUB_FIRST) begin
                o_nxt.clk_line = 1'b1;
                o_nxt.dio_line = 1'b1;
                o_nxt.sub_step = sslseq_pkg::SUB_SECOND;
            end else if (i_cur.sub_step == sslseq_pkg::SUB_SECOND) begin
                o_nxt.clk_line = 1'b0;
                o_nxt.dio_line = 1'b0;
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
                o_nxt.phase    = i_cur.phase + 4'd1;
            end else begin
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
            end
        end else if (i_cur.phase == sslseq_pkg::PH_STOP_CMD
                     || i_cur.phase == sslseq_pkg::PH_STOP_END) begin
            // stop condition: both low, then both high
            if (i_cur.sub_step == sslseq_pkg::SUB_FIRST) begin
                o_nxt.clk_line = 1'b0;
                o_nxt.dio_line = 1'b0;
                o_nxt.sub_step = sslseq_pkg::SUB_SECOND;
            end else if (i_cur.sub_step == sslseq_pkg::SUB_SECOND) begin
                o_nxt.clk_line = 1'b1;
                o_nxt.dio_line = 1'b1;
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
                if (i_cur.phase == sslseq_pkg::PH_STOP_END) begin
                    o_nxt.phase  = sslseq_pkg::PH_START_CMD;
                    o_nxt.active = 1'b0;
                end else begin
                    o_nxt.phase = i_cur.phase + 4'd1;
                end
            end else begin
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
            end
        end else if (i_cur.phase <= sslseq_pkg::PH_DIGIT_3) begin
            // byte phase: eight bits then the ack clock
            if (i_cur.sub_step == sslseq_pkg::SUB_FIRST) begin
                if (i_cur.bit_index > sslseq_pkg::LAST_BIT_IDX) begin
                    o_nxt.bit_index = 4'd0;
                end else if (i_cur.bit_step == sslseq_pkg::BIT_CLK_LOW) begin
                    o_nxt.clk_line = 1'b0;
                    o_nxt.bit_step = sslseq_pkg::BIT_DATA_SET;
                end else if (i_cur.bit_step == sslseq_pkg::BIT_DATA_SET) begin
                    o_nxt.dio_line = byte_sel[i_cur.bit_index[2:0]];
                    o_nxt.bit_step = sslseq_pkg::BIT_CLK_HIGH;
                end else if (i_cur.bit_step == sslseq_pkg::BIT_CLK_HIGH) begin
                    o_nxt.clk_line = 1'b1;
                    o_nxt.bit_step = sslseq_pkg::BIT_CLK_LOW;
                    if (i_cur.bit_index + 4'd1 == sslseq_pkg::BITS_PER_BYTE) begin
                        o_nxt.bit_index = 4'd0;
                        o_nxt.sub_step  = sslseq_pkg::SUB_SECOND;
                    end else begin
                        o_nxt.bit_index = i_cur.bit_index + 4'd1;
                    end
                end else begin
                    o_nxt.bit_step = sslseq_pkg::BIT_CLK_LOW;
                end
            end else if (i_cur.sub_step == sslseq_pkg::SUB_SECOND) begin
                o_nxt.clk_line = 1'b0;
                o_nxt.sub_step = sslseq_pkg::SUB_THIRD;
            end else if (i_cur.sub_step == sslseq_pkg::SUB_THIRD) begin
                o_nxt.clk_line = 1'b1;
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
                o_nxt.phase    = i_cur.phase + 4'd1;
            end else begin
                o_nxt.sub_step = sslseq_pkg::SUB_FIRST;
            end
        end else begin
            // phase out of range ends the frame
            o_nxt.phase  = sslseq_pkg::PH_START_CMD;
            o_nxt.active = 1'b0;
        end
    end

endmodule

/* rtl/core/seven_segment_link_sequencer.sv */
// top level of the seven-segment link sequencer
// Takes one transaction per clock: a load (opcode 1) decodes four ASCII characters into
// segment bytes and marks the block busy; a tick (opcode 0) advances the two-wire write
// frame by one step (start, 0x40, ack, stop, start, 0xC0, four digit bytes lsb first with
// acks, stop). Each accepted transaction yields exactly one result holding the clock and
// data line levels and the busy flag; the result is registered and shows up in the cycle
// after acceptance, and input is taken every cycle while that output register is empty or
// being drained. Ticks while idle return the held line levels with busy low.
module seven_segment_link_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sslseq_in_if.sink    i_in,
    sslseq_out_if.source o_out
);

    sslseq_pkg::t_frame_state r_state;
    sslseq_pkg::t_frame_state n_state;
    sslseq_pkg::t_frame_state step_state;
    sslseq_pkg::t_digit_bytes r_digits;
    logic                     r_out_valid;
    logic                     in_fire;

    // accept while the result register is free or being taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    sslseq_frame_step u_step (
        .i_cur    (r_state),
        .i_digits (r_digits),
        .o_nxt    (step_state)
    );

    // next control state for this transaction
    always_comb begin
        n_state = r_state;
        if (i_in.opcode == sslseq_pkg::OP_LOAD) begin
            n_state.active = 1'b1;
        end else if (r_state.active) begin
            n_state = step_state;
        end
    end

    // control state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= sslseq_pkg::PH_START_CMD;
            r_state.sub_step  <= sslseq_pkg::SUB_FIRST;
            r_state.bit_index <= 4'd0;
            r_state.bit_step  <= sslseq_pkg::BIT_CLK_LOW;
            r_state.active    <= 1'b0;
            r_state.clk_line  <= 1'b1;
            r_state.dio_line  <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // digit byte store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '{default: sslseq_pkg::SEG_BLANK};
        end else if (in_fire && i_in.opcode == sslseq_pkg::OP_LOAD) begin
            r_digits[0] <= sslseq_pkg::decode_char(i_in.char_first);
            r_digits[1] <= sslseq_pkg::decode_char(i_in.char_second);
            r_digits[2] <= sslseq_pkg::decode_char(i_in.char_third);
            r_digits[3] <= sslseq_pkg::decode_char(i_in.char_fourth);
        end
    end

    // result fields follow the updated control state
    assign o_out.valid     = r_out_valid;
    assign o_out.clk_level = r_state.clk_line;
    assign o_out.dio_level = r_state.dio_line;
    assign o_out.busy_res  = r_state.active;

endmodule

/* rtl/core/sslseq_checker.sv */
// port-level checks of the seven-segment link sequencer, bound to the top level
module sslseq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_opcode,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_clk_level,
    input logic       i_out_dio_level,
    input logic       i_out_busy_res
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a free result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // a load transaction gives a busy result next cycle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_opcode == sslseq_pkg::OP_LOAD) |=>
            (i_out_valid && i_out_busy_res))
        else $error("load did not report busy");

    // a stalled result holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_clk_level) && $stable(i_out_dio_level)
             && $stable(i_out_busy_res)))
        else $error("stalled result changed");

endmodule

bind seven_segment_link_sequencer sslseq_checker u_sslseq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_opcode     (i_in.opcode),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_clk_level (o_out.clk_level),
    .i_out_dio_level (o_out.dio_level),
    .i_out_busy_res  (o_out.busy_res)
);

/* tb/sv/tb.sv */
// testbench for the seven-segment link sequencer: directed table, then random frames
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_TAIL    = 250;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic [7:0] char_third;
        logic [7:0] char_fourth;
    } t_item;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
    } t_line;

    typedef struct packed {
        t_item it;
        bit    typed;
        t_line want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    sslseq_in_if  in_ch ();
    sslseq_out_if out_ch ();

    seven_segment_link_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // expected line levels, oldest first
    t_line level_q [$];
    t_row  row_q [$];
    int    err_cnt;
    int    items_sent;
    bit    jitter_on;

    // predicted frame state
    logic [3:0] fr_phase;
    logic [1:0] fr_sub;
    logic [3:0] fr_bit;
    logic [1:0] fr_bstep;
    logic [7:0] seg_byte [4];
    logic       fr_busy;
    logic       line_clk;
    logic       line_dio;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("tb: mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    // ascii code to segment pattern
    function automatic logic [7:0] char_to_segments(input logic [7:0] c);
        case (c)
            "0": return 8'h3F;
            "1": return 8'h06;
            "2": return 8'h5B;
            "3": return 8'h4F;
            "4": return 8'h66;
            "5": return 8'h6D;
            "6": return 8'h7D;
            "7": return 8'h07;
            "8": return 8'h7F;
            "9": return 8'h6F;
            "-": return 8'h40;
            default: return 8'h00;
        endcase
    endfunction

    // one tick of the two-wire frame
    function automatic void frame_advance();
        logic [7:0] tx_byte;
        logic [3:0] didx;
        didx = fr_phase - sslseq_pkg::PH_DIGIT_0;
        case (fr_phase)
            sslseq_pkg::PH_BYTE_CMD: tx_byte = sslseq_pkg::CMD_DATA;
            sslseq_pkg::PH_BYTE_ADR: tx_byte = sslseq_pkg::CMD_ADDR;
            default:                 tx_byte = seg_byte[didx[1:0]];
        endcase
        case (fr_phase)
            sslseq_pkg::PH_START_CMD, sslseq_pkg::PH_START_ADR: begin
                if (fr_sub == sslseq_pkg::SUB_FIRST) begin
                    line_clk = 1'b1;
                    line_dio = 1'b1;
                    fr_sub   = sslseq_pkg::SUB_SECOND;
                end else if (fr_sub == sslseq_pkg::SUB_SECOND) begin
                    line_dio = 1'b0;
                    line_clk = 1'b0;
                    fr_sub   = sslseq_pkg::SUB_FIRST;
                    fr_phase = fr_phase + 4'd1;
                end else begin
                    fr_sub = sslseq_pkg::SUB_FIRST;
                end
            end
            sslseq_pkg::PH_STOP_CMD, sslseq_pkg::PH_STOP_END: begin
                if (fr_sub == sslseq_pkg::SUB_FIRST) begin
                    line_clk = 1'b0;
                    line_dio = 1'b0;
                    fr_sub   = sslseq_pkg::SUB_SECOND;
                end else if (fr_sub == sslseq_pkg::SUB_SECOND) begin
                    line_clk = 1'b1;
                    line_dio = 1'b1;
                    fr_sub   = sslseq_pkg::SUB_FIRST;
                    if (fr_phase == sslseq_pkg::PH_STOP_END) begin
                        fr_phase = sslseq_pkg::PH_START_CMD;
                        fr_busy  = 1'b0;
                    end else begin
                        fr_phase = fr_phase + 4'd1;
                    end
                end else begin
                    fr_sub = sslseq_pkg::SUB_FIRST;
                end
            end
            sslseq_pkg::PH_BYTE_CMD, sslseq_pkg::PH_BYTE_ADR,
            sslseq_pkg::PH_DIGIT_0, sslseq_pkg::PH_DIGIT_1,
            sslseq_pkg::PH_DIGIT_2, sslseq_pkg::PH_DIGIT_3: begin
                if (fr_sub == sslseq_pkg::SUB_FIRST) begin
                    if (fr_bit > sslseq_pkg::LAST_BIT_IDX) begin
                        fr_bit = 4'd0;
                    end else begin
                        case (fr_bstep)
                            sslseq_pkg::BIT_CLK_LOW: begin
                                line_clk = 1'b0;
                                fr_bstep = sslseq_pkg::BIT_DATA_SET;
                            end
                            sslseq_pkg::BIT_DATA_SET: begin
                                line_dio = tx_byte[fr_bit[2:0]];
                                fr_bstep = sslseq_pkg::BIT_CLK_HIGH;
                            end
                            sslseq_pkg::BIT_CLK_HIGH: begin
                                line_clk = 1'b1;
                                fr_bstep = sslseq_pkg::BIT_CLK_LOW;
                                fr_bit   = fr_bit + 4'd1;
                                if (fr_bit == sslseq_pkg::BITS_PER_BYTE) begin
                                    fr_bit = 4'd0;
                                    fr_sub = sslseq_pkg::SUB_SECOND;
                                end
                            end
                            default: fr_bstep = sslseq_pkg::BIT_CLK_LOW;
                        endcase
                    end
                end else if (fr_sub == sslseq_pkg::SUB_SECOND) begin
                    // ack clock, data line left alone
                    line_clk = 1'b0;
                    fr_sub   = sslseq_pkg::SUB_THIRD;
                end else if (fr_sub == sslseq_pkg::SUB_THIRD) begin
                    line_clk = 1'b1;
                    fr_sub   = sslseq_pkg::SUB_FIRST;
                    fr_phase = fr_phase + 4'd1;
                end else begin
                    fr_sub = sslseq_pkg::SUB_FIRST;
                end
            end
            default: begin
                fr_phase = sslseq_pkg::PH_START_CMD;
                fr_busy  = 1'b0;
            end
        endcase
    endfunction

    // expected result of one accepted transaction
    function automatic t_line sequencer_predict(input t_item it);
        t_line res;
        if (it.opcode == sslseq_pkg::OP_LOAD) begin
            seg_byte[0] = char_to_segments(it.char_first);
            seg_byte[1] = char_to_segments(it.char_second);
            seg_byte[2] = char_to_segments(it.char_third);
            seg_byte[3] = char_to_segments(it.char_fourth);
            fr_busy     = 1'b1;
        end else if (fr_busy) begin
            frame_advance();
        end
        res.clk_level = line_clk;
        res.dio_level = line_dio;
        res.busy_res  = fr_busy;
        return res;
    endfunction

    // mostly display characters, sometimes any byte
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return 8'($urandom_range(8'h30, 8'h39));
        end else if (r == 7) begin
            return "-";
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_item random_load();
        t_item it;
        it.opcode      = sslseq_pkg::OP_LOAD;
        it.char_first  = pick_char();
        it.char_second = pick_char();
        it.char_third  = pick_char();
        it.char_fourth = pick_char();
        return it;
    endfunction

    // drive one transaction and record its expected result once accepted
    task automatic push_item(input t_item it, input bit typed, input t_line want);
        t_line pred;
        if (jitter_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= it.opcode;
        in_ch.char_first  <= it.char_first;
        in_ch.char_second <= it.char_second;
        in_ch.char_third  <= it.char_third;
        in_ch.char_fourth <= it.char_fourth;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pred = sequencer_predict(it);
        level_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic add_row(input logic op, input logic [7:0] c1, input logic [7:0] c2,
                           input logic [7:0] c3, input logic [7:0] c4, input bit typed,
                           input logic clk_l, input logic dio_l, input logic busy_l);
        t_row r;
        r.it        = '{op, c1, c2, c3, c4};
        r.typed     = typed;
        r.want      = '{clk_l, dio_l, busy_l};
        row_q.push_back(r);
    endtask

    task automatic check_result(input t_line got);
        t_line want;
        if (level_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
        end else begin
            want = level_q.pop_front();
            if (got.clk_level !== want.clk_level)
                report_mismatch($sformatf("clk_level got %b want %b",
                                          got.clk_level, want.clk_level));
            if (got.dio_level !== want.dio_level)
                report_mismatch($sformatf("dio_level got %b want %b",
                                          got.dio_level, want.dio_level));
            if (got.busy_res !== want.busy_res)
                report_mismatch($sformatf("busy_res got %b want %b",
                                          got.busy_res, want.busy_res));
        end
    endtask

    // result side: check accepted results, stall in bursts
    initial begin
        int    hold;
        t_line got;
        hold = 0;
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.clk_level, out_ch.dio_level, out_ch.busy_res};
                check_result(got);
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (jitter_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 9) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        t_item it;
        int    r;
        int    n;
        err_cnt    = 0;
        items_sent = 0;
        jitter_on  = 1'b0;
        fr_phase   = sslseq_pkg::PH_START_CMD;
        fr_sub     = sslseq_pkg::SUB_FIRST;
        fr_bit     = 4'd0;
        fr_bstep   = sslseq_pkg::BIT_CLK_LOW;
        foreach (seg_byte[k]) seg_byte[k] = 8'h00;
        fr_busy    = 1'b0;
        line_clk   = 1'b1;
        line_dio   = 1'b1;

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= sslseq_pkg::OP_TICK;
        in_ch.char_first  <= 8'h00;
        in_ch.char_second <= 8'h00;
        in_ch.char_third  <= 8'h00;
        in_ch.char_fourth <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, load, frame start, reloads during the frame
        add_row(sslseq_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b1, 1'b1, 1'b0);
        add_row(sslseq_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1'b1, 1'b1, 1'b0);
        add_row(sslseq_pkg::OP_LOAD, "0", "1", "2", "3", 1, 1'b1, 1'b1, 1'b1);
        add_row(sslseq_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b1, 1'b1, 1'b1);
        add_row(sslseq_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1'b0, 1'b0, 1'b1);
        add_row(sslseq_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0, 1'b0, 1'b0);
        add_row(sslseq_pkg::OP_LOAD, "4", "5", "6", "7", 0, 1'b0, 1'b0, 1'b0);
        add_row(sslseq_pkg::OP_LOAD, "8", "9", "-", 8'h00, 0, 1'b0, 1'b0, 1'b0);
        add_row(sslseq_pkg::OP_LOAD, 8'hFF, "/", ":", ",", 0, 1'b0, 1'b0, 1'b0);
        add_row(sslseq_pkg::OP_LOAD, ".", 8'h80, 8'h7F, "-", 0, 1'b0, 1'b0, 1'b0);
        repeat (14) add_row(sslseq_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                            0, 1'b0, 1'b0, 1'b0);
        while (row_q.size() != 0) begin
            t_row row;
            row = row_q.pop_front();
            push_item(row.it, row.typed, row.want);
        end

        // random: mostly whole frames with random digits, some noise
        n = items_sent;
        while (items_sent - n < RANDOM_ITEMS) begin
            jitter_on = (items_sent - n < RANDOM_ITEMS - CALM_TAIL) &&
                        ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 8) begin
                push_item(random_load(), 0, '0);
                repeat ($urandom_range(150, 190)) begin
                    if (items_sent - n >= RANDOM_ITEMS) break;
                    if ($urandom_range(0, 59) == 0) begin
                        push_item(random_load(), 0, '0);
                    end else begin
                        it = '{sslseq_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255))};
                        push_item(it, 0, '0);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    it = '{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255))};
                    push_item(it, 0, '0);
                end
            end
        end
        jitter_on = 1'b0;
        in_ch.valid <= 1'b0;

        // drain
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
